>>> sv/sqt_pkg.sv
// Shared types, register indexes and constant tables of the quantile tracker.
package sqt_pkg;

  localparam int unsigned PosMaxW  = 12;   // position bits for up to 4096 components
  localparam int unsigned DimMaxW  = 13;   // dimension count bits for up to 4096
  localparam int unsigned OrderW   = 17;
  localparam int unsigned DimsCfgW = 7;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned MaxDimsDefault  = 64;
  localparam int unsigned FracBitsDefault = 16;

  localparam logic [CfgIdxW-1:0] CfgOrder = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDims  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNmax  = 2'd2;

  localparam logic [OrderW-1:0]   OrderReset = 17'd32768;
  localparam logic [DimsCfgW-1:0] DimsReset  = 7'd1;
  localparam logic [DataW-1:0]    NmaxReset  = 32'd1000;
  localparam logic [OrderW-1:0]   OrderOne   = 17'd65536;
  localparam logic [31:0]         GammaMin   = 32'd6554;  // 0.1 in Q.16

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic [DataW-1:0]        count;
    logic [PosMaxW-1:0]      pos;
    logic [DimMaxW-1:0]      dims;
    logic                    start;
    logic                    last;
  } sqt_entry_t;

  typedef struct packed {
    logic               start;
    logic [DataW-1:0]   n;
    logic [DimMaxW-1:0] dims;
    logic [DataW-1:0]   nmax;
  } sqt_step_req_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Factors 2^(-2^-j) in Q.32 for j = 1..16, entry 0 holds j = 1.
  function automatic logic [15:0][31:0] pow_tab();
    logic [15:0][31:0] t;
    logic [63:0]       c;
    c = isqrt64(64'd1 << 63);
    for (int j = 0; j < 16; j++) begin
      t[j] = c[31:0];
      c = isqrt64({c[31:0], 32'd0});
    end
    return t;
  endfunction

endpackage

>>> sv/stochastic_quantile_tracker_top.sv
// Top level of the stochastic quantile tracker: config registers and part wiring.
// Each accepted sample gives one result; a plain component passes the back part as a queue
// pop, a memory read and an update with output load (held while the output is blocked), while
// the front keeps taking beats into a two-entry queue. At the first component of every point
// with count n >= 2 the step n^-gamma is recomputed first: a bit-serial gamma divider (skipped
// when max_samples <= 1), a leading-one walk, 16 log2 squaring rounds, an exponent product and
// check (a zero step at once if the exponent is too large), 16 exp2 factor rounds and 1 final
// shift, then the step is handed over.
module stochastic_quantile_tracker_top #(
  parameter int unsigned MAX_DIMS  = sqt_pkg::MaxDimsDefault,
  parameter int unsigned FRAC_BITS = sqt_pkg::FracBitsDefault,
  parameter int unsigned PosW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sqt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sqt_pkg::DataW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sqt_pkg::DataW-1:0]  sample_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [PosW-1:0]                   component_index_o,
  output logic signed [sqt_pkg::DataW-1:0]  quantile_estimate_o,
  output logic [sqt_pkg::DataW-1:0]         point_count_o,
  output logic                              last_of_point_o
);
  import sqt_pkg::*;

  logic [OrderW-1:0]   order_q;
  logic [DimsCfgW-1:0] dims_q;
  logic [DataW-1:0]    nmax_q;

  logic                q_full, q_push, q_valid, q_pop;
  sqt_entry_t          q_in, q_out;
  sqt_step_req_t       step_req;
  logic                step_done;
  logic [DataW-1:0]    step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
      dims_q  <= DimsReset;
      nmax_q  <= NmaxReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgOrder: order_q <= cfg_data_i[OrderW-1:0];
        CfgDims:  dims_q  <= cfg_data_i[DimsCfgW-1:0];
        CfgNmax:  nmax_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sqt_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sample_value_i,
    .dims_cfg_i(dims_q), .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  sqt_queue #(.W($bits(sqt_entry_t))) u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_out)
  );

  sqt_step u_step (
    .clk_i, .rst_ni, .req_i(step_req), .done_o(step_done), .step_o(step)
  );

  sqt_back #(.MAX_DIMS(MAX_DIMS), .FRAC_BITS(FRAC_BITS), .PosW(PosW)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_out), .q_pop_o(q_pop),
    .order_i(order_q), .nmax_i(nmax_q), .step_req_o(step_req),
    .step_done_i(step_done), .step_i(step), .out_valid_o, .out_ready_i,
    .component_index_o, .quantile_estimate_o, .point_count_o, .last_of_point_o
  );
endmodule

>>> sv/sqt_queue.sv
// Two-entry queue between the front and back parts.
module sqt_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q, wr_d, rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = ~wr_q;
    if (pop_i)  rd_d = ~rd_q;
    if (push_i && !pop_i)      cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

>>> sv/sqt_front.sv
// Front part: tracks component position and point count, classifies each beat.
module sqt_front #(
  parameter int unsigned MAX_DIMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sqt_pkg::DataW-1:0]  sample_value_i,
  input  logic [sqt_pkg::DimsCfgW-1:0]      dims_cfg_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output sqt_pkg::sqt_entry_t               q_data_o
);
  import sqt_pkg::*;

  localparam int unsigned PosW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [DataW-1:0]   cnt_q, cnt_d;
  logic [DimMaxW-1:0] dims_c, dims_ext, pos_ext, pos_cur, pos_nxt;
  logic               start, last;

  assign dims_ext = DimMaxW'(dims_cfg_i);

  always_comb begin
    if (dims_ext == '0)                          dims_c = DimMaxW'(1);
    else if (dims_ext > DimMaxW'(MAX_DIMS))      dims_c = DimMaxW'(MAX_DIMS);
    else                                         dims_c = dims_ext;
  end

  assign pos_ext    = DimMaxW'(pos_q);
  assign pos_cur    = (pos_ext >= dims_c) ? '0 : pos_ext;
  assign pos_nxt    = pos_cur + DimMaxW'(1);
  assign start      = (pos_cur == '0);
  assign last       = (pos_nxt == dims_c);
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    cnt_d = cnt_q;
    if (start && cnt_q != '1) cnt_d = cnt_q + DataW'(1);
    pos_d = last ? '0 : pos_nxt[PosW-1:0];
  end

  always_comb begin
    q_data_o.sample = sample_value_i;
    q_data_o.count  = cnt_d;
    q_data_o.pos    = PosMaxW'(pos_cur);
    q_data_o.dims   = dims_c;
    q_data_o.start  = start;
    q_data_o.last   = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else if (q_push_o) begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

>>> sv/sqt_step.sv
// Step unit: n^-gamma in Q0.32 by bit-serial division, log2 squaring and exp2 factors.
module sqt_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sqt_pkg::sqt_step_req_t req_i,
  output logic                  done_o,
  output logic [sqt_pkg::DataW-1:0] step_o
);
  import sqt_pkg::*;

  localparam logic [15:0][31:0] PowTab = pow_tab();
  localparam int unsigned DvW = 51;
  localparam int unsigned DsW = 37;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_LZ   = 8'b0000_0100,
    S_LOG  = 8'b0000_1000,
    S_EXP  = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_POW  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } step_state_e;

  step_state_e      state_q, state_d;
  logic [31:0]      n_q, n_d, gq_q, gq_d, m_q, m_d, step_q, step_d;
  logic [4:0]       p_q, p_d, k_q, k_d;
  logic [20:0]      lq_q, lq_d;
  logic [DvW-1:0]   dvd_q, dvd_d;
  logic [DsW-1:0]   dsr_q, dsr_d, rem_q, rem_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [3:0]       j_q, j_d;
  logic [52:0]      prod_q, prod_d;
  logic [32:0]      r_q, r_d;
  logic [15:0]      f_q, f_d;
  logic             done_d, done_q;

  logic [31:0]      nm1;
  logic [35:0]      den;
  logic [16:0]      dm9;
  logic [32:0]      num;
  logic [DsW:0]     rem_sh;
  logic [63:0]      sq_full;
  logic [31:0]      sq;
  logic [64:0]      rc;
  logic [32:0]      rs;
  logic [36:0]      e_int;

  assign nm1     = req_i.nmax - 32'd1;
  assign den     = 36'(nm1) * 36'd10;
  assign dm9     = 17'(req_i.dims - DimMaxW'(1)) * 17'd9;
  assign num     = 33'(dm9) + 33'(nm1);
  assign rem_sh  = {rem_q, dvd_q[DvW-1]};
  assign sq_full = 64'(m_q) * 64'(m_q);
  assign sq      = sq_full[61:30];
  assign rc      = 65'(r_q) * 65'(PowTab[j_q]);
  assign rs      = r_q >> k_q;
  assign e_int   = prod_q[52:16];

  always_comb begin
    state_d = state_q;
    n_d = n_q; gq_d = gq_q; m_d = m_q; step_d = step_q;
    p_d = p_q; k_d = k_q; lq_d = lq_q; dvd_d = dvd_q; dsr_d = dsr_q;
    rem_d = rem_q; cnt_d = cnt_q; j_d = j_q; prod_d = prod_q; r_d = r_q; f_d = f_q;
    done_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          n_d = req_i.n;
          p_d = 5'd31;
          if (req_i.nmax <= 32'd1) begin
            gq_d    = GammaMin;
            state_d = S_LZ;
          end else begin
            dvd_d   = {num, 17'd0} + DvW'(den);
            dsr_d   = {den, 1'b0};
            rem_d   = '0;
            cnt_d   = 6'(DvW - 1);
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, dsr_q}) begin
          rem_d = DsW'(rem_sh - {1'b0, dsr_q});
          dvd_d = {dvd_q[DvW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DsW-1:0];
          dvd_d = {dvd_q[DvW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          gq_d    = dvd_d[31:0];
          state_d = S_LZ;
        end
      end
      S_LZ: begin
        // walk down to the leading one of n
        if (n_q[p_q] || p_q == '0) begin
          m_d     = (p_q <= 5'd30) ? (n_q << (5'd30 - p_q)) : (n_q >> 1);
          lq_d    = {p_q, 16'd0};
          j_d     = '0;
          state_d = S_LOG;
        end else begin
          p_d = p_q - 5'd1;
        end
      end
      S_LOG: begin
        if (sq[31]) begin
          lq_d[4'd15 - j_q] = 1'b1;
          m_d = sq >> 1;
        end else begin
          m_d = sq;
        end
        j_d = j_q + 4'd1;
        if (j_q == 4'd15) state_d = S_EXP;
      end
      S_EXP: begin
        prod_d  = 53'(gq_q) * 53'(lq_q) + 53'h8000;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (e_int[36:21] != '0) begin
          step_d  = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d     = e_int[20:16];
          f_d     = e_int[15:0];
          r_d     = 33'h1_0000_0000;
          j_d     = '0;
          state_d = S_POW;
        end
      end
      S_POW: begin
        if (f_q[4'd15 - j_q]) r_d = rc[64:32];
        j_d = j_q + 4'd1;
        if (j_q == 4'd15) state_d = S_FIN;
      end
      S_FIN: begin
        step_d  = rs[32] ? '1 : rs[31:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; gq_q <= gq_d; m_q <= m_d; p_q <= p_d; k_q <= k_d; lq_q <= lq_d;
    dvd_q <= dvd_d; dsr_q <= dsr_d; rem_q <= rem_d; cnt_q <= cnt_d; j_q <= j_d;
    prod_q <= prod_d; r_q <= r_d; f_q <= f_d; step_q <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;
  assign step_o = step_q;
endmodule

>>> sv/sqt_back.sv
// Back part: estimate memory, per-component update and output register.
module sqt_back #(
  parameter int unsigned MAX_DIMS  = 64,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned PosW      = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  sqt_pkg::sqt_entry_t               q_data_i,
  output logic                              q_pop_o,
  input  logic [sqt_pkg::OrderW-1:0]        order_i,
  input  logic [sqt_pkg::DataW-1:0]         nmax_i,
  output sqt_pkg::sqt_step_req_t            step_req_o,
  input  logic                              step_done_i,
  input  logic [sqt_pkg::DataW-1:0]         step_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [PosW-1:0]                   component_index_o,
  output logic signed [sqt_pkg::DataW-1:0]  quantile_estimate_o,
  output logic [sqt_pkg::DataW-1:0]         point_count_o,
  output logic                              last_of_point_o
);
  import sqt_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_STEP = 4'b0010,
    B_READ = 4'b0100,
    B_UPD  = 4'b1000
  } back_state_e;

  localparam logic [48:0] RoundAdd = 49'd1 << (47 - FRAC_BITS);

  back_state_e             state_q, state_d;
  sqt_entry_t              ent_q;
  logic [DataW-1:0]        step_q;
  logic signed [DataW-1:0] rd_q;
  logic signed [DataW-1:0] mem_q [MAX_DIMS];
  logic                    out_valid_q;
  logic [PosW-1:0]         idx_q;
  logic signed [DataW-1:0] est_q;
  logic [DataW-1:0]        cnt_q;
  logic                    last_q;

  logic                    need_step, upd_fire, ge;
  logic [OrderW-1:0]       ord, w;
  logic [48:0]             prod, prod_r;
  logic signed [33:0]      d, sum;
  logic signed [DataW-1:0] est_new;
  logic [PosW-1:0]         idx;

  assign idx       = ent_q.pos[PosW-1:0];
  assign need_step = q_data_i.start && (q_data_i.count > DataW'(1));
  assign q_pop_o   = (state_q == B_IDLE) && q_valid_i;
  assign upd_fire  = (state_q == B_UPD) && (!out_valid_q || out_ready_i);

  always_comb begin
    step_req_o.start = q_pop_o && need_step;
    step_req_o.n     = q_data_i.count;
    step_req_o.dims  = q_data_i.dims;
    step_req_o.nmax  = nmax_i;
  end

  always_comb begin
    ord    = (order_i > OrderOne) ? OrderOne : order_i;
    ge     = (rd_q >= ent_q.sample);
    w      = ge ? (OrderOne - ord) : ord;
    prod   = 49'(w) * 49'(step_q);
    prod_r = (prod + RoundAdd) >> (48 - FRAC_BITS);
    d      = signed'(prod_r[33:0]);
    sum    = ge ? (34'(rd_q) - d) : (34'(rd_q) + d);
    if (ent_q.count <= DataW'(1))            est_new = ent_q.sample;
    else if (sum > 34'sh0_7FFF_FFFF)         est_new = 32'sh7FFF_FFFF;
    else if (sum < -34'sh0_8000_0000)        est_new = 32'sh8000_0000;
    else                                     est_new = sum[31:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (q_valid_i) state_d = need_step ? B_STEP : B_READ;
      B_STEP: if (step_done_i) state_d = B_READ;
      B_READ: state_d = B_UPD;
      B_UPD:  if (upd_fire) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) ent_q <= q_data_i;
    if (state_q == B_READ) rd_q <= mem_q[idx];
    if (upd_fire) begin
      mem_q[idx] <= est_new;
      idx_q      <= idx;
      est_q      <= est_new;
      cnt_q      <= ent_q.count;
      last_q     <= ent_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_STEP && step_done_i) step_q <= step_i;
      if (upd_fire)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign component_index_o   = idx_q;
  assign quantile_estimate_o = est_q;
  assign point_count_o       = cnt_q;
  assign last_of_point_o     = last_q;

  a_done_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_done_i |-> state_q == B_STEP)
    else $error("step result arrived outside step wait");
  a_upd_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_UPD && out_valid_q && !out_ready_i) |=> state_q == B_UPD)
    else $error("update left while output blocked");
  a_upd_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> out_valid_q)
    else $error("update did not load a result");
  a_read_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_READ |=> state_q == B_UPD)
    else $error("memory read not followed by update");
endmodule
